FILE: rtl/tab_expander_with_stop_list_defines.svh
// Assertion helpers used by the tab expander core.
`ifndef TAB_EXPANDER_WITH_STOP_LIST_DEFINES_SVH
`define TAB_EXPANDER_WITH_STOP_LIST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TEWSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tab expander check failed");

// The consequent must hold in the cycle after the antecedent.
`define TEWSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tab expander check failed");

`endif

FILE: rtl/tewsl_pkg.sv
package tewsl_pkg;

   // Fixed character codes.
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_NUL   = 8'd0;

   // Default spacing after the explicit list, and how much of the list is used.
   localparam int TAB_WIDTH = 8;
   localparam int MAX_STOPS = 7;

   // Number of explicit stop registers.
   localparam int NUM_STOP_REGS = 7;

   localparam logic [15:0] SAT16 = 16'hFFFF;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_NUM_STOPS = 3'd0;
   localparam logic [2:0] REG_STOP_1    = 3'd1;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [2:0]                          num_stops;
      logic [NUM_STOP_REGS-1:0][7:0]       stops;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic       stop_error;
      logic [7:0] out_count;
      logic [7:0] out_byte;
   } rsp_type;

   // Explicit stop at list position idx; positions past the list read as zero.
   function automatic logic [7:0] stop_at(cfg_type cfg, logic [2:0] idx);
      logic [7:0] s;
      s = 8'd0;
      for (int i = 0; i < NUM_STOP_REGS; i++) begin
         if (idx == 3'(i)) begin
            s = cfg.stops[i];
         end
      end
      return s;
   endfunction

endpackage

FILE: rtl/tab_expander_with_stop_list.sv
// A request is captured in the input register, and its result is registered in the result register that drives rsp.
// Throughput: one request per cycle while the result register is not stalled; the line state updates once per byte.
// A full result register stalls the input register, and that in turn holds off req.
// Reset (synchronous, active high) clears the line state, the halt flag and both
// stages, sets num_stops to 0 and the stops to columns 8, 16, ... 56.
module tab_expander_with_stop_list (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [15:8] out_count
   output logic [0:0]  rsp_tuser,   // [0] stop_error
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tewsl_pkg::*;

   cfg_type cfg;
   rsp_type rsp;
   logic    rsp_load;
   logic    out_ready;

   tewsl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tewsl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .out_ready  (out_ready),
      .rsp_load   (rsp_load),
      .rsp        (rsp)
   );

   tewsl_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .rsp_load   (rsp_load),
      .rsp        (rsp),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/tewsl_csr.sv
module tewsl_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output tewsl_pkg::cfg_type   cfg
);
   import tewsl_pkg::*;

   logic [2:0]                    num_stops_ff;
   logic [2:0]                    num_stops_in;
   logic [NUM_STOP_REGS-1:0][7:0] stops_ff;
   logic [NUM_STOP_REGS-1:0][7:0] stops_in;
   logic [2:0]                    reg_idx;
   logic                          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write decode.
   always_comb begin
      num_stops_in = num_stops_ff;
      stops_in     = stops_ff;
      if (wr_en) begin
         if (reg_idx == REG_NUM_STOPS) begin
            num_stops_in = csr_pwdata[2:0];
         end
         for (int i = 0; i < NUM_STOP_REGS; i++) begin
            if (reg_idx == REG_STOP_1 + 3'(i)) begin
               stops_in[i] = csr_pwdata[7:0];
            end
         end
      end
   end

   // Stop registers reset to every eighth column.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_stops_ff <= 3'd0;
         for (int i = 0; i < NUM_STOP_REGS; i++) begin
            stops_ff[i] <= 8'(8 * (i + 1));
         end
      end else begin
         num_stops_ff <= num_stops_in;
         stops_ff     <= stops_in;
      end
   end

   // Read back.
   always_comb begin
      csr_prdata = 32'd0;
      if (reg_idx == REG_NUM_STOPS) begin
         csr_prdata = {29'd0, num_stops_ff};
      end
      for (int i = 0; i < NUM_STOP_REGS; i++) begin
         if (reg_idx == REG_STOP_1 + 3'(i)) begin
            csr_prdata = {24'd0, stops_ff[i]};
         end
      end
   end

   assign cfg.num_stops = num_stops_ff;
   assign cfg.stops     = stops_ff;

endmodule

FILE: rtl/tewsl_core.sv
`include "tab_expander_with_stop_list_defines.svh"

module tewsl_core (
   input  logic                 clock,
   input  logic                 reset,
   input  tewsl_pkg::cfg_type   cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_byte,
   input  logic                 out_ready,
   output logic                 rsp_load,
   output tewsl_pkg::rsp_type   rsp
);
   import tewsl_pkg::*;

   // Input register.
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [7:0]  in_byte_in;

   // Line state.
   logic [15:0] column_ff;
   logic [15:0] column_in;
   logic [15:0] next_stop_ff;
   logic [15:0] next_stop_in;
   logic [2:0]  stops_used_ff;
   logic [2:0]  stops_used_in;
   logic        halted_ff;
   logic        halted_in;

   logic        fire;
   logic [2:0]  limit;
   logic        take;
   logic        from_list;
   logic [7:0]  list_stop;
   logic        bad_stop;
   logic [16:0] stop_sum;
   logic [16:0] col_sum;
   logic [15:0] stop_new;
   logic [15:0] run;

   assign fire       = in_valid_ff & out_ready;
   assign req_tready = ~in_valid_ff | fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Stop update that happens before the byte is applied.
   assign limit     = (cfg.num_stops < 3'(MAX_STOPS)) ? cfg.num_stops : 3'(MAX_STOPS);
   assign take      = column_ff >= next_stop_ff;
   assign from_list = stops_used_ff < limit;
   assign list_stop = stop_at(cfg, stops_used_ff);
   assign bad_stop  = take && from_list &&
                      ((list_stop == 8'd0) || ({8'd0, list_stop} <= next_stop_ff));
   assign stop_sum  = {1'b0, next_stop_ff} + 17'(TAB_WIDTH);
   assign col_sum   = {1'b0, column_ff} + 17'd1;

   always_comb begin
      if (!take) begin
         stop_new = next_stop_ff;
      end else if (from_list) begin
         stop_new = {8'd0, list_stop};
      end else begin
         stop_new = stop_sum[16] ? SAT16 : stop_sum[15:0];
      end
   end

   assign run = stop_new - column_ff;

   // Byte handling and result.
   always_comb begin
      column_in      = column_ff;
      next_stop_in   = next_stop_ff;
      stops_used_in  = stops_used_ff;
      halted_in      = halted_ff;
      rsp_load       = 1'b0;
      rsp.out_byte   = in_byte_ff;
      rsp.out_count  = 8'd1;
      rsp.stop_error = 1'b0;
      if (fire && !halted_ff) begin
         if (bad_stop) begin
            halted_in      = 1'b1;
            rsp_load       = 1'b1;
            rsp.out_byte   = CH_NUL;
            rsp.out_count  = 8'd0;
            rsp.stop_error = 1'b1;
         end else begin
            next_stop_in = stop_new;
            if (take && from_list) begin
               stops_used_in = stops_used_ff + 3'd1;
            end
            case (in_byte_ff)
               CH_TAB: begin
                  if (column_ff < stop_new) begin
                     column_in     = stop_new;
                     rsp_load      = 1'b1;
                     rsp.out_byte  = CH_SPACE;
                     rsp.out_count = (run[15:8] != 8'd0) ? 8'hFF : run[7:0];
                  end
               end
               CH_NL: begin
                  column_in     = 16'd0;
                  next_stop_in  = 16'd0;
                  stops_used_in = 3'd0;
                  rsp_load      = 1'b1;
               end
               default: begin
                  column_in = col_sum[16] ? SAT16 : col_sum[15:0];
                  rsp_load  = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         column_ff     <= 16'd0;
         next_stop_ff  <= 16'd0;
         stops_used_ff <= 3'd0;
         halted_ff     <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         column_ff     <= column_in;
         next_stop_ff  <= next_stop_in;
         stops_used_ff <= stops_used_in;
         halted_ff     <= halted_in;
      end
      in_byte_ff <= in_byte_in;
   end

   // Once halted, the block stays halted until reset.
   `TEWSL_ASSERT_NEXT(a_halt_sticks, clock, reset, halted_ff, halted_ff)
   // An error result always halts the block.
   `TEWSL_ASSERT_NEXT(a_err_halts, clock, reset, rsp_load && rsp.stop_error, halted_ff)
   // A halted block emits nothing.
   `TEWSL_ASSERT_NOW(a_halted_quiet, clock, reset, halted_ff, !rsp_load)
   // A newline that passes restarts the line.
   `TEWSL_ASSERT_NEXT(a_nl_restart, clock, reset,
      rsp_load && !rsp.stop_error && (in_byte_ff == CH_NL),
      (column_ff == 16'd0) && (next_stop_ff == 16'd0) && (stops_used_ff == 3'd0))

endmodule

FILE: rtl/tewsl_rsp_reg.sv
module tewsl_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_load,
   input  tewsl_pkg::rsp_type   rsp,
   output logic                 out_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic [0:0]           rsp_tuser
);
   import tewsl_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   // The slot can take a new result when empty or being drained this cycle.
   assign out_ready = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_load) begin
         valid_in = 1'b1;
         data_in  = rsp;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.out_count, data_ff.out_byte};
   assign rsp_tuser  = data_ff.stop_error;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tewsl_pkg::*;

   // Run shape.
   localparam int RANDOM_ITEMS     = 1800;
   localparam int OPENING_ROWS     = 30;
   localparam int LONG_HOLD_AFTER  = 300;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES     = 4;
   localparam int TAIL_CYCLES      = 20;

   typedef enum logic [0:0] {
      ROW_CSR,
      ROW_BYTE
   } row_kind_type;

   // One step of the opening plan: a register write or one request byte.
   typedef struct {
      row_kind_type kind;
      logic [2:0]   reg_idx;
      logic [7:0]   value;
      bit           typed;
      rsp_type      run;
   } plan_row_type;

   typedef logic [7:0] stop_list_type [NUM_STOP_REGS];

   localparam rsp_type NO_RUN    = '0;
   localparam rsp_type ERROR_RUN = {1'b1, 8'd0, CH_NUL};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] out_byte, [15:8] out_count
   logic [0:0]  rsp_tuser;    // [0] stop_error
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Local copy of the configuration and of the line state.
   logic [2:0]  cfg_num_stops;
   logic [7:0]  cfg_stop [NUM_STOP_REGS];
   logic [15:0] line_column;
   logic [15:0] line_next_stop;
   logic [2:0]  line_stops_used;
   bit          line_halted;

   rsp_type expected_runs [$];
   int      mismatches = 0;
   int      runs_seen  = 0;
   int      burst_left = 0;

   // Directed opening: reset defaults, extreme stops, then the widest run.
   plan_row_type opening_plan [OPENING_ROWS] = '{
      '{ROW_BYTE, REG_NUM_STOPS, 8'h41,    1'b1, {1'b0, 8'd1, 8'h41}},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b1, {1'b0, 8'd7, CH_SPACE}},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b1, {1'b0, 8'd8, CH_SPACE}},
      '{ROW_BYTE, REG_NUM_STOPS, 8'h00,    1'b1, {1'b0, 8'd1, 8'h00}},
      '{ROW_BYTE, REG_NUM_STOPS, 8'hFF,    1'b1, {1'b0, 8'd1, 8'hFF}},
      '{ROW_BYTE, REG_NUM_STOPS, CH_NL,    1'b1, {1'b0, 8'd1, CH_NL}},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b1, {1'b0, 8'd8, CH_SPACE}},
      '{ROW_BYTE, REG_NUM_STOPS, CH_NL,    1'b1, {1'b0, 8'd1, CH_NL}},
      '{ROW_CSR,  REG_NUM_STOPS,        8'd7,   1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1,           8'd1,   1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1 + 3'd1,    8'd2,   1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1 + 3'd2,    8'd3,   1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1 + 3'd3,    8'd100, 1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1 + 3'd4,    8'd200, 1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1 + 3'd5,    8'd254, 1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1 + 3'd6,    8'd255, 1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, 8'h78,    1'b1, {1'b0, 8'd1, 8'h78}},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_NL,    1'b1, {1'b0, 8'd1, CH_NL}},
      '{ROW_CSR,  REG_NUM_STOPS, 8'd1,     1'b0, NO_RUN},
      '{ROW_CSR,  REG_STOP_1,    8'd255,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b1, {1'b0, 8'd255, CH_SPACE}},
      '{ROW_BYTE, REG_NUM_STOPS, CH_TAB,   1'b0, NO_RUN},
      '{ROW_BYTE, REG_NUM_STOPS, CH_NL,    1'b1, {1'b0, 8'd1, CH_NL}}
   };

   tab_expander_with_stop_list i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] sat_add16(input logic [15:0] a, input int unsigned b);
      int unsigned s;
      s = a + b;
      return (s > SAT16) ? SAT16 : 16'(s);
   endfunction

   function automatic void reset_expander();
      cfg_num_stops = '0;
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
         cfg_stop[k] = 8'(TAB_WIDTH * (k + 1));
      end
      line_column     = '0;
      line_next_stop  = '0;
      line_stops_used = '0;
      line_halted     = 1'b0;
   endfunction

   // Advances the line state by one byte; returns 1 when the byte gives a run.
   function automatic bit expand_byte(input logic [7:0] ch, output rsp_type run);
      int unsigned lim;
      int unsigned span;
      logic [7:0]  new_stop;
      run = '0;
      if (line_halted) begin
         return 1'b0;
      end
      lim = (cfg_num_stops < MAX_STOPS) ? cfg_num_stops : MAX_STOPS;

      // The stop moves on before the byte is looked at, newline included.
      if (line_column >= line_next_stop) begin
         if (line_stops_used < lim) begin
            new_stop = cfg_stop[line_stops_used];
            if (new_stop == 8'd0 || new_stop <= line_next_stop) begin
               line_halted    = 1'b1;
               run.out_byte   = CH_NUL;
               run.stop_error = 1'b1;
               return 1'b1;
            end
            line_next_stop  = 16'(new_stop);
            line_stops_used = line_stops_used + 3'd1;
         end else begin
            line_next_stop = sat_add16(line_next_stop, TAB_WIDTH);
         end
      end

      if (ch == CH_TAB) begin
         // Only a saturated line can leave a tab with nothing to fill.
         if (line_column >= line_next_stop) begin
            return 1'b0;
         end
         span          = line_next_stop - line_column;
         line_column   = line_next_stop;
         run.out_byte  = CH_SPACE;
         run.out_count = (span > 255) ? 8'd255 : 8'(span);
         return 1'b1;
      end
      if (ch == CH_NL) begin
         line_column     = '0;
         line_next_stop  = '0;
         line_stops_used = '0;
         run.out_byte    = CH_NL;
         run.out_count   = 8'd1;
         return 1'b1;
      end
      line_column   = sat_add16(line_column, 1);
      run.out_byte  = ch;
      run.out_count = 8'd1;
      return 1'b1;
   endfunction

   // Strictly rising stops for the first n entries; the unused ones are noise.
   function automatic void build_stops(input logic [2:0] n, output stop_list_type stops);
      int prev;
      int room;
      int step;
      prev = 0;
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
         if (k < n) begin
            room = 255 - prev - (n - 1 - k);
            if ($urandom_range(0, 3) == 0) begin
               step = $urandom_range(1, room);
            end else begin
               step = $urandom_range(1, (room < 24) ? room : 24);
            end
            prev     = prev + step;
            stops[k] = 8'(prev);
         end else begin
            stops[k] = 8'($urandom_range(0, 255));
         end
      end
   endfunction

   // APB write with random upper data bits; the predictor keeps the low bits only.
   task automatic write_csr(input logic [2:0] idx, input logic [7:0] value);
      logic [31:0] word;
      word = $urandom();
      if (idx == REG_NUM_STOPS) begin
         word[2:0] = value[2:0];
      end else begin
         word[7:0] = value;
      end
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_NUM_STOPS) begin
         cfg_num_stops = word[2:0];
      end else begin
         cfg_stop[idx - REG_STOP_1] = word[7:0];
      end
      @(posedge clock);
   endtask

   task automatic load_config(input logic [2:0] n, input stop_list_type stops);
      write_csr(REG_NUM_STOPS, {5'd0, n});
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
         write_csr(REG_STOP_1 + 3'(k), stops[k]);
      end
   endtask

   // Offers one request in bursts with random gaps and records its expected run.
   task automatic push_byte(input logic [7:0] ch, input bit typed, input rsp_type typed_run);
      rsp_type run;
      bit      has_run;
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      has_run = expand_byte(ch, run);
      if (typed) begin
         expected_runs.push_back(typed_run);
      end else if (has_run) begin
         expected_runs.push_back(run);
      end
      burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic req_quiet();
      if (burst_left != 0) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
      end
   endtask

   // Idle point for register writes: everything out, then spare cycles
   // for requests that give no run.
   task automatic drain_runs();
      req_quiet();
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random lines of text; the phase always closes its last line.
   task automatic send_text(input int n_items, input int nl_pct);
      int pick;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            push_byte(CH_TAB, 1'b0, NO_RUN);
         end else if (pick < 30 + nl_pct) begin
            push_byte(CH_NL, 1'b0, NO_RUN);
         end else if (pick < 90) begin
            push_byte(8'($urandom_range(32, 126)), 1'b0, NO_RUN);
         end else begin
            push_byte(8'($urandom_range(0, 255)), 1'b0, NO_RUN);
         end
      end
      push_byte(CH_NL, 1'b0, NO_RUN);
   endtask

   // Result checker: each accepted run against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         runs_seen++;
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected run: expected none, actual byte %0d count %0d error %0d",
                     $time, got.out_byte, got.out_count, got.stop_error);
            mismatches++;
         end else begin
            want = expected_runs.pop_front();
            if (got.out_byte !== want.out_byte) begin
               $display("%0t: out_byte: expected %0d, actual %0d",
                        $time, want.out_byte, got.out_byte);
               mismatches++;
            end
            if (got.out_count !== want.out_count) begin
               $display("%0t: out_count: expected %0d, actual %0d",
                        $time, want.out_count, got.out_count);
               mismatches++;
            end
            if (got.stop_error !== want.stop_error) begin
               $display("%0t: stop_error: expected %0d, actual %0d",
                        $time, want.stop_error, got.stop_error);
               mismatches++;
            end
         end
      end
   end

   // Result sink: segments of varying stall rate, plus one long hold-off while
   // requests are still being offered, so the block backs up into req.
   initial begin : rsp_sink
      int  seg_left;
      int  stall_pct;
      bit  long_hold_done;
      seg_left       = 0;
      stall_pct      = 0;
      long_hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!long_hold_done && runs_seen >= LONG_HOLD_AFTER && req_tvalid) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(8, 80);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 20;
                  2: stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            seg_left--;
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      #7_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin : stimulus
      stop_list_type stops;
      logic [2:0]    n;
      int            sent;
      int            phase;
      int            n_items;
      int            bad_pos;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset_expander();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed opening.
      for (int r = 0; r < OPENING_ROWS; r++) begin
         if (opening_plan[r].kind == ROW_CSR) begin
            drain_runs();
            write_csr(opening_plan[r].reg_idx, opening_plan[r].value);
         end else begin
            push_byte(opening_plan[r].value, opening_plan[r].typed, opening_plan[r].run);
         end
      end

      // Random text under a new, well-formed stop list per phase; the first two
      // phases use the full list and no list at all.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         n_items = $urandom_range(100, 250);
         if (phase == 0) begin
            n = 3'd7;
         end else if (phase == 1) begin
            n = 3'd0;
         end else begin
            n = 3'($urandom_range(0, 7));
         end
         drain_runs();
         build_stops(n, stops);
         load_config(n, stops);
         send_text(n_items, $urandom_range(2, 12));
         sent  = sent + n_items + 1;
         phase++;
      end

      // A bad stop halts the block for good, so it comes last: walk up to it
      // with tabs, trip it with a newline or any other byte, then check that
      // nothing more comes out.
      drain_runs();
      n       = 3'($urandom_range(1, 7));
      bad_pos = $urandom_range(0, n - 1);
      build_stops(n, stops);
      stops[bad_pos] = (bad_pos == 0) ? 8'd0 : 8'($urandom_range(0, stops[bad_pos - 1]));
      load_config(n, stops);
      repeat (bad_pos) push_byte(CH_TAB, 1'b0, NO_RUN);
      if ($urandom_range(0, 1) == 1) begin
         push_byte(CH_NL, 1'b1, ERROR_RUN);
      end else begin
         push_byte(8'($urandom_range(0, 255)), 1'b1, ERROR_RUN);
      end
      repeat (12) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_RUN);

      req_quiet();
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_runs.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
